// File: hw/rtl/csi_pkg.sv
// Shared types, constants and helpers of the cubic setpoint interpolator.
// No dependencies; csi_mul and the core refer to it by scoped names.
package csi_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned FRAC_W = 32;
  localparam int unsigned NUM_W  = 36;             // signed Hermite numerators
  localparam int unsigned QUO_W  = NUM_W + FRAC_W;  // divider numerator width
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned RAM_DEPTH   = 8;
  localparam int unsigned RAM_ENTRIES = 6;

  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [ADDR_W-1:0] {
    ADDR_PREV_POS,
    ADDR_PREV_VEL,
    ADDR_COEF_A,
    ADDR_COEF_B,
    ADDR_COEF_C,
    ADDR_COEF_D
  } addr_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_D,
    ST_RD_C,
    ST_DIV_V,
    ST_NUM_CN,
    ST_NUM_NV,
    ST_NUM_SUM,
    ST_DIV_B_GO,
    ST_DIV_B,
    ST_DIV_A_GO,
    ST_DIV_A,
    ST_WR,
    ST_LD_A,
    ST_LD_B,
    ST_LD_C,
    ST_LD_D,
    ST_K2,
    ST_K3,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_ADD_D,
    ST_ADD_C,
    ST_OUT
  } st_e;

  typedef enum logic [2:0] {
    MS_A_K3,
    MS_B_K2,
    MS_C_K,
    MS_A_3K2,
    MS_B_2K
  } mstep_e;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SUM
  } mul_ph_e;

  function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] x,
                                                       input logic signed [WORD_W-1:0] y);
    logic signed [WORD_W:0] s;
    s = {x[WORD_W-1], x} + {y[WORD_W-1], y};
    if (s[WORD_W] != s[WORD_W-1]) begin
      sat_add = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      sat_add = s[WORD_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/csi_stream_if.sv
// Valid/ready channels of the interpolator: tick input and setpoint output.
// Standalone; no package dependency.
interface csi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_position;
  modport source (output valid, output target_position, input ready);
  modport sink   (input valid, input target_position, output ready);
endinterface

interface csi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] set_position;
  logic signed [31:0] set_velocity;
  logic               segment_start;
  modport source (output valid, output set_position, output set_velocity,
                  output segment_start, input ready);
  modport sink   (input valid, input set_position, input set_velocity,
                  input segment_start, output ready);
endinterface

// File: hw/rtl/csi_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module csi_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/csi_div.sv
// Divider by a fixed constant: reciprocal multiply on 16-bit digits, MSB first.
// One to three chained passes give the quotient by DIVISOR, its square or cube.
// No package dependency.
module csi_div #(
  parameter int unsigned NUM_W   = 68,
  parameter int unsigned DIVISOR = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [1:0]       passes_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned DIG_W  = 16;
  localparam int unsigned DIGITS = (NUM_W + DIG_W - 1) / DIG_W;
  localparam int unsigned PAD_W  = DIGITS * DIG_W;
  localparam int unsigned REM_W  = 6;                // DIVISOR up to 64
  localparam int unsigned T_W    = REM_W + DIG_W;
  localparam int unsigned SH     = T_W + REM_W;      // exact for any digit below 2**T_W
  localparam int unsigned P_W    = T_W + SH;
  localparam int unsigned CNT_W  = $clog2(DIGITS + 1);
  localparam logic [SH-1:0] RECIP =
    SH'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PAD_W-1:0] work_q;
  logic [REM_W-1:0] rem_q;
  logic [T_W-1:0]   t_q;
  logic [DIG_W-1:0] qd_q;
  logic [CNT_W-1:0] dig_q;
  logic [1:0]       pass_q;
  logic             busy_q, phase_q, done_q, last_dig;
  logic [T_W-1:0]   t, back;
  logic [P_W-1:0]   prod;

  assign t        = {rem_q, work_q[PAD_W-1 -: DIG_W]};
  assign prod     = P_W'(t) * P_W'(RECIP);
  assign back     = T_W'(qd_q) * T_W'(DIVISOR);
  assign last_dig = busy_q && phase_q && (dig_q == CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      dig_q   <= '0;
      pass_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        dig_q   <= CNT_W'(DIGITS);
        pass_q  <= passes_i;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (dig_q == CNT_W'(1)) begin
            dig_q  <= CNT_W'(DIGITS);
            pass_q <= pass_q - 1'b1;
            if (pass_q == 2'd1) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end else begin
            dig_q <= dig_q - 1'b1;
          end
        end
      end
    end
  end

  // even cycle: quotient digit; odd cycle: remainder and shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= PAD_W'(num_i);
      rem_q  <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        t_q  <= t;
        qd_q <= prod[SH +: DIG_W];
      end else begin
        work_q <= {work_q[PAD_W-DIG_W-1:0], qd_q};
        rem_q  <= last_dig ? '0 : REM_W'(t_q - back);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = work_q[NUM_W-1:0];

endmodule

// File: hw/rtl/csi_mul.sv
// Saturating multiply of a signed Q32.32 coefficient by a small unsigned factor.
// Two 32-bit partial products over successive cycles; uses csi_pkg.
module csi_mul #(
  parameter int unsigned MUL_W = 18
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [csi_pkg::WORD_W-1:0]      coef_i,
  input  logic [MUL_W-1:0]                       mult_i,
  output logic                                   done_o,
  output logic signed [csi_pkg::WORD_W-1:0]      prod_o
);

  localparam int unsigned LW = MUL_W + 32;
  localparam int unsigned HW = MUL_W + 33;
  localparam int unsigned FW = MUL_W + 65;

  csi_pkg::mul_ph_e ph_q, ph_d;

  logic signed [csi_pkg::WORD_W-1:0] coef_q, prod_q;
  logic [MUL_W-1:0]                  m_q;
  logic [LW-1:0]                     lo_q;
  logic signed [HW-1:0]              hi_q;
  logic [FW-1:0]                     full;
  logic                              fits;
  logic                              done_q;

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      csi_pkg::MUL_IDLE: if (start_i) ph_d = csi_pkg::MUL_LO;
      csi_pkg::MUL_LO:   ph_d = csi_pkg::MUL_HI;
      csi_pkg::MUL_HI:   ph_d = csi_pkg::MUL_SUM;
      csi_pkg::MUL_SUM:  ph_d = csi_pkg::MUL_IDLE;
      default:           ph_d = csi_pkg::MUL_IDLE;
    endcase
  end

  assign full = {hi_q, 32'b0} + FW'(lo_q);
  assign fits = (&full[FW-1:csi_pkg::WORD_W-1]) | ~(|full[FW-1:csi_pkg::WORD_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= csi_pkg::MUL_IDLE;
      done_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      done_q <= (ph_q == csi_pkg::MUL_SUM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_q == csi_pkg::MUL_IDLE && start_i) begin
      coef_q <= coef_i;
      m_q    <= mult_i;
    end
    if (ph_q == csi_pkg::MUL_LO) begin
      lo_q <= LW'(coef_q[31:0] * m_q);
    end
    if (ph_q == csi_pkg::MUL_HI) begin
      hi_q <= HW'($signed(coef_q[63:32]) * $signed({1'b0, m_q}));
    end
    if (ph_q == csi_pkg::MUL_SUM) begin
      if (fits) begin
        prod_q <= full[csi_pkg::WORD_W-1:0];
      end else begin
        prod_q <= full[FW-1] ? csi_pkg::WORD_MIN : csi_pkg::WORD_MAX;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// File: hw/rtl/cubic_setpoint_interpolator_core.sv
// Cubic Hermite setpoint interpolator: one position/velocity setpoint per tick.
// A plain tick runs four coefficient RAM reads, then five saturating
// products through the shared two-partial-product multiplier, sums and
// the output load. In a tick that opens a segment, the divisions by N,
// N^2 and N^3 run as one, two and three passes of the divide-by-N unit,
// each pass over 68 bits, followed by six RAM write-backs. After reset
// and after every start_position write, a sweep of the six entries loads
// the coefficient RAM and no item is taken meanwhile.
// The output register lets a new item in while a result waits.
// Uses csi_pkg, csi_stream_if, csi_ram, csi_div and csi_mul.
module cubic_setpoint_interpolator_core #(
  parameter int unsigned SEGMENT_TICKS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i,
  csi_in_if.sink             in_i,
  csi_out_if.source          out_o
);

  localparam int unsigned N      = SEGMENT_TICKS;
  localparam int unsigned TICK_W = $clog2(N + 1);
  localparam int unsigned KW     = $clog2(N);
  localparam int unsigned MUL_W  = (3 * KW > 2 * KW + 2) ? 3 * KW : 2 * KW + 2;
  localparam int unsigned NW     = csi_pkg::NUM_W;
  localparam int unsigned QW     = csi_pkg::QUO_W;
  localparam int unsigned WW     = csi_pkg::WORD_W;

  csi_pkg::st_e    state_q, state_d;
  csi_pkg::mstep_e step_q;
  csi_pkg::addr_e  raddr, waddr;

  logic [2:0]          cnt_q;
  logic [TICK_W-1:0]   tick_q;
  logic signed [31:0]  start_q;
  logic                out_valid_q, seg_q, out_seg_q;

  logic signed [31:0]  p1_q, d_q, c_q, v1_q;
  logic signed [WW-1:0] a_q, b_q, acc_p_q, acc_v_q;
  logic signed [32:0]  diff_q, diff_d;
  logic signed [NW-1:0] cn_q, nv_q, num_b_q, num_a_q, d36;
  logic [KW-1:0]       k_q;
  logic [2*KW-1:0]     k2_q;
  logic [3*KW-1:0]     k3_q;
  logic signed [31:0]  pos_q, vel_q;

  logic                we;
  logic [WW-1:0]       wdata, rdata;
  logic                div_start, div_done;
  logic [QW-1:0]       div_num, div_quo;
  logic [1:0]          div_passes;
  logic                mul_start, mul_done;
  logic signed [WW-1:0] mul_coef, mul_prod;
  logic [MUL_W-1:0]    mul_m;
  logic                in_acc, seg_now, out_free, sweep_last;

  function automatic logic signed [WW-1:0] to_coef(input logic neg, input logic [QW-1:0] q);
    if (|q[QW-1:WW-1]) begin
      to_coef = neg ? csi_pkg::WORD_MIN : csi_pkg::WORD_MAX;
    end else begin
      to_coef = neg ? -q[WW-1:0] : q[WW-1:0];
    end
  endfunction

  function automatic logic signed [31:0] trunc32(input logic signed [WW-1:0] v);
    trunc32 = v[WW-1:32] + 32'(v[WW-1] & (|v[31:0]));
  endfunction

  function automatic logic [NW-1:0] mag36(input logic signed [NW-1:0] v);
    mag36 = v[NW-1] ? -v : v;
  endfunction

  assign seg_now    = tick_q >= TICK_W'(N);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign sweep_last = cnt_q == 3'(csi_pkg::RAM_ENTRIES - 1);
  assign diff_d     = 33'(p1_q) - 33'(d_q);
  assign d36        = NW'(diff_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csi_pkg::ST_INIT:     if (sweep_last) state_d = csi_pkg::ST_IDLE;
      csi_pkg::ST_IDLE: begin
        if (in_acc) state_d = seg_now ? csi_pkg::ST_RD_D : csi_pkg::ST_LD_A;
      end
      csi_pkg::ST_RD_D:     state_d = csi_pkg::ST_RD_C;
      csi_pkg::ST_RD_C:     state_d = csi_pkg::ST_DIV_V;
      csi_pkg::ST_DIV_V:    if (div_done) state_d = csi_pkg::ST_NUM_CN;
      csi_pkg::ST_NUM_CN:   state_d = csi_pkg::ST_NUM_NV;
      csi_pkg::ST_NUM_NV:   state_d = csi_pkg::ST_NUM_SUM;
      csi_pkg::ST_NUM_SUM:  state_d = csi_pkg::ST_DIV_B_GO;
      csi_pkg::ST_DIV_B_GO: state_d = csi_pkg::ST_DIV_B;
      csi_pkg::ST_DIV_B:    if (div_done) state_d = csi_pkg::ST_DIV_A_GO;
      csi_pkg::ST_DIV_A_GO: state_d = csi_pkg::ST_DIV_A;
      csi_pkg::ST_DIV_A:    if (div_done) state_d = csi_pkg::ST_WR;
      csi_pkg::ST_WR:       if (sweep_last) state_d = csi_pkg::ST_K2;
      csi_pkg::ST_LD_A:     state_d = csi_pkg::ST_LD_B;
      csi_pkg::ST_LD_B:     state_d = csi_pkg::ST_LD_C;
      csi_pkg::ST_LD_C:     state_d = csi_pkg::ST_LD_D;
      csi_pkg::ST_LD_D:     state_d = csi_pkg::ST_K2;
      csi_pkg::ST_K2:       state_d = csi_pkg::ST_K3;
      csi_pkg::ST_K3:       state_d = csi_pkg::ST_MUL_GO;
      csi_pkg::ST_MUL_GO:   state_d = csi_pkg::ST_MUL_WAIT;
      csi_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          state_d = (step_q == csi_pkg::MS_B_2K) ? csi_pkg::ST_ADD_D : csi_pkg::ST_MUL_GO;
        end
      end
      csi_pkg::ST_ADD_D:    state_d = csi_pkg::ST_ADD_C;
      csi_pkg::ST_ADD_C:    state_d = csi_pkg::ST_OUT;
      csi_pkg::ST_OUT:      if (out_free) state_d = csi_pkg::ST_IDLE;
      default:              state_d = csi_pkg::ST_INIT;
    endcase
    if (cfg_we_i) state_d = csi_pkg::ST_INIT;
  end

  // control outputs
  always_comb begin
    we         = 1'b0;
    waddr      = csi_pkg::addr_e'(cnt_q);
    wdata      = '0;
    raddr      = csi_pkg::ADDR_PREV_POS;
    div_start  = 1'b0;
    div_num    = '0;
    div_passes = 2'd1;
    mul_start  = 1'b0;
    unique case (state_q)
      csi_pkg::ST_INIT: begin
        we = 1'b1;
        case (waddr)
          csi_pkg::ADDR_PREV_POS: wdata = WW'(start_q);
          csi_pkg::ADDR_COEF_D:   wdata = WW'(start_q);
          default:                wdata = '0;
        endcase
      end
      csi_pkg::ST_WR: begin
        we = 1'b1;
        case (waddr)
          csi_pkg::ADDR_PREV_POS: wdata = WW'(p1_q);
          csi_pkg::ADDR_PREV_VEL: wdata = WW'(v1_q);
          csi_pkg::ADDR_COEF_A:   wdata = a_q;
          csi_pkg::ADDR_COEF_B:   wdata = b_q;
          csi_pkg::ADDR_COEF_C:   wdata = WW'(c_q);
          csi_pkg::ADDR_COEF_D:   wdata = WW'(d_q);
          default:                wdata = '0;
        endcase
      end
      csi_pkg::ST_IDLE: raddr = seg_now ? csi_pkg::ADDR_PREV_POS : csi_pkg::ADDR_COEF_A;
      csi_pkg::ST_RD_D: raddr = csi_pkg::ADDR_PREV_VEL;
      csi_pkg::ST_RD_C: begin
        div_start = 1'b1;
        div_num   = QW'(diff_d[32] ? -diff_d : diff_d);
      end
      csi_pkg::ST_DIV_B_GO: begin
        div_start  = 1'b1;
        div_num    = {mag36(num_b_q), 32'b0};
        div_passes = 2'd2;
      end
      csi_pkg::ST_DIV_A_GO: begin
        div_start  = 1'b1;
        div_num    = {mag36(num_a_q), 32'b0};
        div_passes = 2'd3;
      end
      csi_pkg::ST_LD_A:   raddr = csi_pkg::ADDR_COEF_B;
      csi_pkg::ST_LD_B:   raddr = csi_pkg::ADDR_COEF_C;
      csi_pkg::ST_LD_C:   raddr = csi_pkg::ADDR_COEF_D;
      csi_pkg::ST_MUL_GO: mul_start = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    unique case (step_q)
      csi_pkg::MS_A_K3: begin
        mul_coef = a_q;
        mul_m    = MUL_W'(k3_q);
      end
      csi_pkg::MS_B_K2: begin
        mul_coef = b_q;
        mul_m    = MUL_W'(k2_q);
      end
      csi_pkg::MS_C_K: begin
        mul_coef = {c_q, 32'b0};
        mul_m    = MUL_W'(k_q);
      end
      csi_pkg::MS_A_3K2: begin
        mul_coef = a_q;
        mul_m    = MUL_W'({k2_q, 1'b0}) + MUL_W'(k2_q);
      end
      csi_pkg::MS_B_2K: begin
        mul_coef = b_q;
        mul_m    = MUL_W'({k_q, 1'b0});
      end
      default: begin
        mul_coef = '0;
        mul_m    = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csi_pkg::ST_INIT;
      cnt_q       <= '0;
      tick_q      <= TICK_W'(N);
      start_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= csi_pkg::MS_A_K3;
    end else begin
      state_q <= state_d;
      if (out_o.ready) out_valid_q <= 1'b0;
      if ((state_q == csi_pkg::ST_INIT || state_q == csi_pkg::ST_WR) && !sweep_last) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
      if (state_q == csi_pkg::ST_INIT) tick_q <= TICK_W'(N);
      if (state_q == csi_pkg::ST_K3) step_q <= csi_pkg::MS_A_K3;
      if (state_q == csi_pkg::ST_MUL_WAIT && mul_done && step_q != csi_pkg::MS_B_2K) begin
        step_q <= csi_pkg::mstep_e'(step_q + 1'b1);
      end
      if (state_q == csi_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
        tick_q      <= TICK_W'(k_q) + 1'b1;
      end
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
        cnt_q   <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      csi_pkg::ST_IDLE: begin
        if (in_acc) begin
          p1_q  <= in_i.target_position;
          seg_q <= seg_now;
          k_q   <= seg_now ? '0 : tick_q[KW-1:0];
        end
      end
      csi_pkg::ST_RD_D: d_q <= rdata[31:0];
      csi_pkg::ST_RD_C: begin
        c_q    <= rdata[31:0];
        diff_q <= diff_d;
      end
      csi_pkg::ST_DIV_V: begin
        if (div_done) v1_q <= diff_q[32] ? -div_quo[31:0] : div_quo[31:0];
      end
      csi_pkg::ST_NUM_CN:  cn_q <= NW'(c_q) * $signed(NW'(N));
      csi_pkg::ST_NUM_NV:  nv_q <= NW'(v1_q) * $signed(NW'(N));
      csi_pkg::ST_NUM_SUM: begin
        num_b_q <= (d36 <<< 1) + d36 - (cn_q <<< 1) - nv_q;
        num_a_q <= cn_q + nv_q - (d36 <<< 1);
      end
      csi_pkg::ST_DIV_B: if (div_done) b_q <= to_coef(num_b_q[NW-1], div_quo);
      csi_pkg::ST_DIV_A: if (div_done) a_q <= to_coef(num_a_q[NW-1], div_quo);
      csi_pkg::ST_LD_A:  a_q <= rdata;
      csi_pkg::ST_LD_B:  b_q <= rdata;
      csi_pkg::ST_LD_C:  c_q <= rdata[31:0];
      csi_pkg::ST_LD_D:  d_q <= rdata[31:0];
      csi_pkg::ST_K2:    k2_q <= k_q * k_q;
      csi_pkg::ST_K3:    k3_q <= k2_q * k_q;
      csi_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (step_q)
            csi_pkg::MS_A_K3:  acc_p_q <= mul_prod;
            csi_pkg::MS_A_3K2: acc_v_q <= mul_prod;
            csi_pkg::MS_B_2K:  acc_v_q <= csi_pkg::sat_add(acc_v_q, mul_prod);
            default:           acc_p_q <= csi_pkg::sat_add(acc_p_q, mul_prod);
          endcase
        end
      end
      csi_pkg::ST_ADD_D: acc_p_q <= csi_pkg::sat_add(acc_p_q, {d_q, 32'b0});
      csi_pkg::ST_ADD_C: acc_v_q <= csi_pkg::sat_add(acc_v_q, {c_q, 32'b0});
      csi_pkg::ST_OUT: begin
        if (out_free) begin
          pos_q     <= trunc32(acc_p_q);
          vel_q     <= trunc32(acc_v_q);
          out_seg_q <= seg_q;
        end
      end
      default: ;
    endcase
  end

  csi_ram #(
    .WIDTH (WW),
    .DEPTH (csi_pkg::RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  csi_div #(
    .NUM_W   (QW),
    .DIVISOR (N)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .passes_i (div_passes),
    .done_o   (div_done),
    .quo_o    (div_quo)
  );

  csi_mul #(
    .MUL_W (MUL_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .coef_i  (mul_coef),
    .mult_i  (mul_m),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_i.ready          = state_q == csi_pkg::ST_IDLE;
  assign out_o.valid         = out_valid_q;
  assign out_o.set_position  = pos_q;
  assign out_o.set_velocity  = vel_q;
  assign out_o.segment_start = out_seg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) tick_q <= TICK_W'(N))
    else $error("tick index beyond segment length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_acc && !cfg_we_i |=> state_q != csi_pkg::ST_IDLE)
    else $error("accepted item did not start processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mul_done |-> state_q == csi_pkg::ST_MUL_WAIT)
    else $error("multiplier result arrived outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_done |-> state_q == csi_pkg::ST_DIV_V || state_q == csi_pkg::ST_DIV_B ||
                                state_q == csi_pkg::ST_DIV_A)
    else $error("divider result arrived outside a wait state");

endmodule
